>>> sv/phase_accumulator_wave_oscillator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the phase accumulator oscillator
// Concurrent checks clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PHASE_ACCUMULATOR_WAVE_OSCILLATOR_UNIT_ASSERT_SVH
`define PHASE_ACCUMULATOR_WAVE_OSCILLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PAWO_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAWO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pawo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawo_pkg
// Shared types, constants and tables of the phase accumulator oscillator.
// ----------------------------------------------------------------------------
package pawo_pkg;

  localparam int PhaseBitsDef     = 32;
  localparam int SineIndexBitsDef = 12;

  localparam int SampleBits = 16;
  localparam int MagBits    = 15;
  localparam int WaveBits   = 2;
  localparam int StepBits   = 31;

  localparam int SineAmp   = 25000;
  localparam int SquareAmp = 30000;
  localparam int TriRise   = 30000;
  localparam int TriFall   = 90000;
  localparam int TriSlope  = 1875;
  localparam int TriShift  = 6;

  // pi/2 in unsigned Q62
  localparam logic [63:0] HalfPiQ62   = 64'h6487ED5110B4611A;
  localparam logic [3:0]  TaylorTerms = 4'd12;

  typedef enum logic [WaveBits-1:0] {
    WaveSine     = 2'd0,
    WaveSquare   = 2'd1,
    WaveTriangle = 2'd2
  } wave_e;

  typedef enum logic [3:0] {
    FillNext,
    FillMul,
    FillMulEnd,
    FillAcc,
    FillScaleLo,
    FillScaleHi,
    FillWrite,
    FillDone
  } fill_state_e;

  typedef struct packed {
    logic               en;
    logic [MagBits-1:0] mag;
  } fill_wr_t;

  typedef struct packed {
    logic [1:0] quad;
    logic       peak;
  } sine_pos_t;

  // low 64 bits of ceil(2^(64+l)/d); bit 64 is always set for these divisors
  function automatic logic [63:0] recip_of(input int unsigned d, input int unsigned l);
    logic [127:0] num;
    num = (128'd1 << (64 + l)) + 128'(d) - 128'd1;
    return 64'(num / 128'(d));
  endfunction

  // ceil(log2((2i)(2i+1))) for Taylor term i
  function automatic logic [3:0] taylor_shift(input logic [3:0] idx);
    logic [3:0] s;
    case (idx)
      4'd1:    s = 4'd3;
      4'd2:    s = 4'd5;
      4'd3:    s = 4'd6;
      4'd4:    s = 4'd7;
      4'd5:    s = 4'd7;
      4'd6:    s = 4'd8;
      4'd7:    s = 4'd8;
      4'd8:    s = 4'd9;
      4'd9:    s = 4'd9;
      4'd10:   s = 4'd9;
      4'd11:   s = 4'd9;
      4'd12:   s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // reciprocal of (2i)(2i+1) for Taylor term i, exact floor for 64-bit dividends
  function automatic logic [63:0] taylor_recip(input logic [3:0] idx);
    logic [63:0] r;
    case (idx)
      4'd1:    r = recip_of(6, 3);
      4'd2:    r = recip_of(20, 5);
      4'd3:    r = recip_of(42, 6);
      4'd4:    r = recip_of(72, 7);
      4'd5:    r = recip_of(110, 7);
      4'd6:    r = recip_of(156, 8);
      4'd7:    r = recip_of(210, 8);
      4'd8:    r = recip_of(272, 9);
      4'd9:    r = recip_of(342, 9);
      4'd10:   r = recip_of(420, 9);
      4'd11:   r = recip_of(506, 9);
      4'd12:   r = recip_of(600, 10);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/pawo_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pawo_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/pawo_sine_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawo_sine_fill
// Serial builder of the quarter-wave sine table: Q62 Taylor series with a
// 32x32 multiplier, one partial product at a time; term divisors by reciprocal multiply.
// ----------------------------------------------------------------------------
module pawo_sine_fill import pawo_pkg::*; #(
  parameter int SineIndexBits = SineIndexBitsDef,
  localparam int AddrBits = SineIndexBits - 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output fill_wr_t            wr_o,
  output logic [AddrBits-1:0] wr_addr_o,
  output logic                done_o
);

  localparam logic [63:0] XStep = HalfPiQ62 >> AddrBits;

  fill_state_e state_q, state_d;

  logic [AddrBits-1:0] m_q;
  logic [63:0]         x_q;
  logic [63:0]         x2_q;
  logic [63:0]         sum_q;
  logic [63:0]         mul_a_q;
  logic [63:0]         mul_b_q;
  logic [127:0]        acc_q;
  logic [1:0]          pp_cnt_q;
  logic                sq_q;
  logic                rc_q;
  logic [3:0]          i_q;
  logic [63:0]         dv_q;
  logic [MagBits-1:0]  lo_q;
  logic [MagBits-1:0]  mag_q;

  logic [31:0]  a_sel, b_sel;
  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [127:0] acc_d;
  logic [63:0]  prod;
  logic [3:0]   q_sh;
  logic [128:0] q_full;
  logic [64:0]  q_hi;
  logic [63:0]  quo;
  logic [45:0]  lo_prod;
  logic [47:0]  hi_prod;
  logic [47:0]  v_sum;
  logic [16:0]  v;
  logic [MagBits-1:0] mag_d;

  // partial products: a0b0, a0b1, a1b0, a1b1
  always_comb begin
    a_sel = pp_cnt_q[1] ? mul_a_q[63:32] : mul_a_q[31:0];
    b_sel = pp_cnt_q[0] ? mul_b_q[63:32] : mul_b_q[31:0];
    case (pp_cnt_q)
      2'd0:    pp_sh = 7'd0;
      2'd3:    pp_sh = 7'd64;
      default: pp_sh = 7'd32;
    endcase
    pp    = 64'(a_sel) * 64'(b_sel);
    acc_d = acc_q + ({64'b0, pp} << pp_sh);
    prod  = acc_q[125:62];
  end

  // quotient: (dv * (2^64 + recip)) >> (64 + shift)
  always_comb begin
    q_sh   = taylor_shift(i_q);
    q_full = {1'b0, acc_q} + {1'b0, dv_q, 64'b0};
    q_hi   = q_full[128:64];
    quo    = 64'(q_hi >> q_sh);
  end

  always_comb begin
    lo_prod = 46'(sum_q[30:0]) * 46'(SineAmp);
    hi_prod = 48'(sum_q[63:31]) * 48'(SineAmp);
    v_sum   = hi_prod + 48'(lo_q);
    v       = v_sum[47:31];
    mag_d   = (v > 17'(SineAmp)) ? MagBits'(SineAmp) : v[MagBits-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FillNext:    state_d = (m_q == '0) ? FillWrite : FillMul;
      FillMul:     state_d = (pp_cnt_q == 2'd3) ? FillMulEnd : FillMul;
      FillMulEnd:  state_d = (!sq_q && rc_q) ? FillAcc : FillMul;
      FillAcc:     state_d = (i_q == TaylorTerms) ? FillScaleLo : FillMul;
      FillScaleLo: state_d = FillScaleHi;
      FillScaleHi: state_d = FillWrite;
      FillWrite:   state_d = (&m_q) ? FillDone : FillNext;
      FillDone:    state_d = FillDone;
      default:     state_d = FillNext;
    endcase
  end

  always_comb begin
    wr_o.en   = (state_q == FillWrite);
    wr_o.mag  = mag_q;
    wr_addr_o = m_q;
    done_o    = (state_q == FillDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FillNext;
      m_q     <= '0;
      x_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FillWrite) begin
        m_q <= m_q + AddrBits'(1);
        x_q <= x_q + XStep;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FillNext: begin
        mul_a_q  <= x_q;
        mul_b_q  <= x_q;
        acc_q    <= '0;
        pp_cnt_q <= 2'd0;
        sq_q     <= 1'b1;
        rc_q     <= 1'b0;
        mag_q    <= '0;
      end
      FillMul: begin
        acc_q    <= acc_d;
        pp_cnt_q <= pp_cnt_q + 2'd1;
      end
      FillMulEnd: begin
        if (sq_q) begin
          x2_q     <= prod;
          sum_q    <= x_q;
          mul_a_q  <= x_q;
          mul_b_q  <= prod;
          acc_q    <= '0;
          pp_cnt_q <= 2'd0;
          sq_q     <= 1'b0;
          i_q      <= 4'd1;
        end else if (!rc_q) begin
          dv_q     <= prod;
          mul_a_q  <= prod;
          mul_b_q  <= taylor_recip(i_q);
          acc_q    <= '0;
          pp_cnt_q <= 2'd0;
          rc_q     <= 1'b1;
        end else begin
          dv_q <= quo;
          rc_q <= 1'b0;
        end
      end
      FillAcc: begin
        sum_q    <= i_q[0] ? sum_q - dv_q : sum_q + dv_q;
        mul_a_q  <= dv_q;
        mul_b_q  <= x2_q;
        acc_q    <= '0;
        pp_cnt_q <= 2'd0;
        i_q      <= i_q + 4'd1;
      end
      FillScaleLo: lo_q  <= lo_prod[45:31];
      FillScaleHi: mag_q <= mag_d;
      default: ;
    endcase
  end

endmodule

>>> sv/pawo_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawo_shape
// Waveform shaping: sine from the quarter table, square and triangle
// computed from the phase.
// ----------------------------------------------------------------------------
module pawo_shape import pawo_pkg::*; #(
  parameter int PhaseBits = PhaseBitsDef
) (
  input  logic [PhaseBits-1:0]         phase_i,
  input  logic [WaveBits-1:0]          waveform_i,
  input  sine_pos_t                    sine_pos_i,
  input  logic [MagBits-1:0]           rom_mag_i,
  output logic signed [SampleBits-1:0] sample_o
);

  localparam int W  = PhaseBits + 11;
  localparam int Sh = PhaseBits - TriShift;
  localparam logic [PhaseBits-1:0] Half = {1'b1, {(PhaseBits-1){1'b0}}};
  localparam logic [W-1:0] RiseOfs = W'(TriRise) << Sh;
  localparam logic [W-1:0] FallOfs = W'(TriFall) << Sh;
  localparam logic signed [SampleBits-1:0] SquarePos = SampleBits'(SquareAmp);
  localparam logic signed [SampleBits-1:0] SinePeak  = SampleBits'(SineAmp);

  logic                         up;
  logic [W-1:0]                 num, tri_a, tri_b, diff, tri_mag;
  logic                         tri_neg;
  logic signed [SampleBits-1:0] tri_abs, tri_val, sine_abs, sine_val, sq_val;

  always_comb begin
    up      = phase_i <= Half;
    num     = W'(phase_i) * W'(TriSlope);
    tri_a   = up ? num : FallOfs;
    tri_b   = up ? RiseOfs : num;
    tri_neg = tri_a < tri_b;
    diff    = tri_neg ? tri_b - tri_a : tri_a - tri_b;
    tri_mag = diff >> Sh;
    tri_abs = SampleBits'(tri_mag);
    tri_val = tri_neg ? -tri_abs : tri_abs;

    sq_val = up ? SquarePos : -SquarePos;

    sine_abs = sine_pos_i.peak ? SinePeak : SampleBits'(rom_mag_i);
    sine_val = sine_pos_i.quad[1] ? -sine_abs : sine_abs;

    case (waveform_i)
      WaveSine:     sample_o = sine_val;
      WaveSquare:   sample_o = sq_val;
      WaveTriangle: sample_o = tri_val;
      default:      sample_o = '0;
    endcase
  end

endmodule

>>> sv/phase_accumulator_wave_oscillator_unit.sv
`timescale 1ns / 1ps
`include "phase_accumulator_wave_oscillator_unit_assert.svh"
// ----------------------------------------------------------------------------
// phase_accumulator_wave_oscillator_unit
// Numerically controlled oscillator: sine, square or triangle samples from a
// phase accumulator advanced by one phase step per input word.
// ----------------------------------------------------------------------------
// After reset the quarter-wave sine table (2^(SineIndexBits-2) entries) is
// built serially; in_ready_o stays low meanwhile, while waveform writes are
// taken at any time. Then one word is accepted per cycle while the output
// is not stalled, and its sample passes through the table read and input
// register, then the output register.
module phase_accumulator_wave_oscillator_unit import pawo_pkg::*; #(
  parameter int PhaseBits     = PhaseBitsDef,
  parameter int SineIndexBits = SineIndexBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [StepBits-1:0]          phase_inc_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SampleBits-1:0] sample_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [WaveBits-1:0]          cfg_waveform_i
);

  localparam int AddrBits = SineIndexBits - 2;
  localparam logic [AddrBits:0] QuarterFull = {1'b1, {AddrBits{1'b0}}};

  fill_wr_t            fill_wr;
  logic [AddrBits-1:0] fill_addr;
  logic                fill_done;

  logic [PhaseBits-1:0]  phase_q, phase_next;
  logic [WaveBits-1:0]   waveform_q;
  logic                  s1_v_q, out_v_q;
  logic                  in_fire, s1_move;
  logic [PhaseBits-1:0]  s1_ph_q;
  logic [WaveBits-1:0]   s1_wf_q;
  sine_pos_t             s1_sine_q, sine_pos;
  logic [SineIndexBits-1:0] k;
  logic [AddrBits:0]     m_full;
  logic [AddrBits-1:0]   rd_addr;
  logic [MagBits-1:0]    rom_mag;
  logic signed [SampleBits-1:0] s1_sample, out_sample_q;

  pawo_sine_fill #(
    .SineIndexBits(SineIndexBits)
  ) u_fill (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_o     (fill_wr),
    .wr_addr_o(fill_addr),
    .done_o   (fill_done)
  );

  pawo_ram #(
    .Width(MagBits),
    .Depth(2 ** AddrBits)
  ) u_sine_ram (
    .clk_i  (clk_i),
    .we_i   (fill_wr.en),
    .waddr_i(fill_addr),
    .wdata_i(fill_wr.mag),
    .re_i   (in_fire),
    .raddr_i(rd_addr),
    .rdata_o(rom_mag)
  );

  // quarter-wave mirror of the table index
  always_comb begin
    k             = phase_q[PhaseBits-1 -: SineIndexBits];
    sine_pos.quad = k[SineIndexBits-1 -: 2];
    m_full        = sine_pos.quad[0] ? QuarterFull - {1'b0, k[AddrBits-1:0]}
                                     : {1'b0, k[AddrBits-1:0]};
    sine_pos.peak = m_full[AddrBits];
    rd_addr       = m_full[AddrBits-1:0];
  end

  assign phase_next  = phase_q + PhaseBits'(phase_inc_i);
  assign s1_move     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o  = fill_done && (!s1_v_q || s1_move);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      waveform_q <= WaveSine;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_next;
      end
      if (cfg_valid_i) begin
        waveform_q <= cfg_waveform_i;
      end
      s1_v_q  <= in_fire || (s1_v_q && !s1_move);
      out_v_q <= s1_move || (out_v_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ph_q   <= phase_q;
      s1_wf_q   <= waveform_q;
      s1_sine_q <= sine_pos;
    end
    if (s1_move) begin
      out_sample_q <= s1_sample;
    end
  end

  pawo_shape #(
    .PhaseBits(PhaseBits)
  ) u_shape (
    .phase_i   (s1_ph_q),
    .waveform_i(s1_wf_q),
    .sine_pos_i(s1_sine_q),
    .rom_mag_i (rom_mag),
    .sample_o  (s1_sample)
  );

  assign out_valid_o = out_v_q;
  assign sample_o    = out_sample_q;

  `PAWO_ASSERT_IMPL(a_ready_after_fill, in_ready_o, fill_done, "input ready before table built")
  `PAWO_ASSERT_IMPL(a_fill_quiet, fill_wr.en, !in_ready_o && !s1_v_q, "table write during operation")
  `PAWO_ASSERT_NEXT(a_phase_adv, in_fire, phase_q == $past(phase_next), "phase did not advance")
  `PAWO_ASSERT_NEXT(a_s1_hold, s1_v_q && !s1_move, s1_v_q && $stable(s1_ph_q), "stalled word lost")

endmodule
